>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ETFI_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition that must never be seen outside reset
`define ETFI_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> hdl/etfi_pkg.sv
package etfi_pkg;

  // Port widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int CNT_W  = 12;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 4;

  // Default fraction bits of the fixed-point format (Q4.28)
  localparam int FRAC_BITS_DEF = 28;

  // Multiplier digit width: operand B is consumed this many bits per cycle
  localparam int MUL_DIG_W = 32;

  // Fractal modes (code 3 runs as mandelbrot)
  localparam logic [MODE_W-1:0] MODE_MANDEL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JULIA   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRICORN = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_JRE   = 2'd1;
  localparam logic [1:0] REG_JIM   = 2'd2;
  localparam logic [1:0] REG_MAXIT = 2'd3;

  // Reset values
  localparam logic signed [DATA_W-1:0] JRE_RST   = -32'sd188377266;
  localparam logic signed [DATA_W-1:0] JIM_RST   = -32'sd103132902;
  localparam logic [CNT_W-1:0]         MAXIT_RST = 12'd255;

endpackage

>>> hdl/escape_time_fractal_iterator_unit.sv
// Escape-time iterator for mandelbrot, julia and tricorn sets.
// Request channel: drive in_point_re/in_point_im (signed fixed point, FRAC_BITS
// fraction bits) and pulse start; the request is taken on a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: out_valid is high for exactly one cycle with
// out_iteration_count; the receiver cannot stall it, and a new request may be
// taken in the same cycle the strobe is shown.
// Config: APB-style write/read of fractal_mode, julia_const_re/im and the
// iteration limit at byte addresses 0, 4, 8, 12; write only while idle.
// Datapath: one shared multiplier (MW x 32 bits, MW = 32 at the default format)
// computes re^2, im^2 and re*im one after the other, ND digit passes each
// (ND = 1 at the default format). Each iteration takes the z magnitudes (S_MAG),
// runs the digit passes (S_MUL), makes the bound test (S_TEST) and, unless
// that test ends the request, updates z (S_UPD); the strobe is registered
// from the S_TEST that ends the request.
// Reset: registers return to mandelbrot, K = -0.70176 - 0.3842i, limit 255;
// any request in flight is dropped.
`include "assert_macros.svh"

module escape_time_fractal_iterator_unit
  import etfi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_point_re,
  input  logic signed [DATA_W-1:0] in_point_im,
  // result channel
  output logic                     out_valid,
  output logic [CNT_W-1:0]         out_iteration_count,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  // z width: |z| <= 4 + |c| after a step, with c any 32-bit value
  localparam int ZW  = ((FRAC_BITS + 3 > DATA_W - 1) ? FRAC_BITS + 3 : DATA_W - 1) + 2;
  localparam int MW  = ZW - 1;
  localparam int PW  = 2 * MW;
  localparam int ND  = (MW + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int BPW = ND * MUL_DIG_W;
  localparam int DGW = (ND > 1) ? $clog2(ND) : 1;
  localparam int QW  = MW + MUL_DIG_W;
  localparam logic [PW:0] LIMIT = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_MUL,
    S_TEST,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    SEL_RR,
    SEL_II,
    SEL_RI,
    SEL_DONE
  } sel_t;

  // control registers
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic signed [DATA_W-1:0] jre_r, jim_r;
  logic [CNT_W-1:0]    max_iter_r;

  // datapath registers
  logic signed [ZW-1:0]     z_re_r, z_re_nxt, z_im_r, z_im_nxt;
  logic signed [DATA_W-1:0] c_re_r, c_re_nxt, c_im_r, c_im_nxt;
  logic [MW-1:0]            mr_r, mr_nxt, mi_r, mi_nxt;
  logic                     rineg_r, rineg_nxt;
  logic [BPW-1:0]           b_sh_r, b_sh_nxt;
  sel_t                     sel_r, sel_nxt, ptgt_r, ptgt_nxt;
  logic [DGW-1:0]           dig_r, dig_nxt;
  logic                     pfirst_r, pfirst_nxt;
  logic [QW-1:0]            prod_r, prod_nxt;
  logic [PW-1:0]            rr_r, rr_nxt, ii_r, ii_nxt, ri_r, ri_nxt;
  logic signed [PW:0]       diff_r, diff_nxt, ris_r, ris_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;

  // combinational helpers
  logic signed [ZW-1:0] z_re_neg, z_im_neg;
  logic [MW-1:0]        mag_re, mag_im;
  logic [MW-1:0]        a_op;
  logic [MUL_DIG_W-1:0] b_dig;
  logic [PW-1:0]        tgt_cur, acc_base, acc_sum;
  logic [PW:0]          sum_sq;
  logic signed [PW:0]   ri_pos, nre_sh, nim_sh;
  logic                 cfg_wr;

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign pready              = 1'b1;
  assign cfg_wr              = psel & penable & pwrite;

  // register read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = DATA_W'(mode_r);
      REG_JRE:   prdata = jre_r;
      REG_JIM:   prdata = jim_r;
      REG_MAXIT: prdata = DATA_W'(max_iter_r);
      default:   prdata = '0;
    endcase
  end

  // magnitudes of z
  assign z_re_neg = -z_re_r;
  assign z_im_neg = -z_im_r;
  assign mag_re   = z_re_r[ZW-1] ? z_re_neg[MW-1:0] : z_re_r[MW-1:0];
  assign mag_im   = z_im_r[ZW-1] ? z_im_neg[MW-1:0] : z_im_r[MW-1:0];

  // shared multiplier: A times the top digit of the B shift register
  always_comb begin
    case (sel_r)
      SEL_RR:  a_op = mr_r;
      SEL_II:  a_op = mi_r;
      SEL_RI:  a_op = mr_r;
      default: a_op = '0;
    endcase
  end
  assign b_dig    = b_sh_r[BPW-1 -: MUL_DIG_W];
  assign prod_nxt = QW'(a_op) * QW'(b_dig);

  // accumulator: most significant digit first
  always_comb begin
    case (ptgt_r)
      SEL_RR:  tgt_cur = rr_r;
      SEL_II:  tgt_cur = ii_r;
      SEL_RI:  tgt_cur = ri_r;
      default: tgt_cur = '0;
    endcase
  end
  assign acc_base = pfirst_r ? '0 : (tgt_cur << MUL_DIG_W);
  assign acc_sum  = acc_base + PW'(prod_r);

  // bound test and floor-shifted terms
  assign sum_sq = {1'b0, rr_r} + {1'b0, ii_r};
  assign ri_pos = $signed({1'b0, ri_r});
  assign nre_sh = diff_r >>> FRAC_BITS;
  assign nim_sh = ris_r >>> (FRAC_BITS - 1);

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    pvalid_nxt    = 1'b0;
    z_re_nxt      = z_re_r;
    z_im_nxt      = z_im_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    mr_nxt        = mr_r;
    mi_nxt        = mi_r;
    rineg_nxt     = rineg_r;
    b_sh_nxt      = b_sh_r;
    sel_nxt       = sel_r;
    ptgt_nxt      = ptgt_r;
    dig_nxt       = dig_r;
    pfirst_nxt    = pfirst_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    ri_nxt        = ri_r;
    diff_nxt      = diff_r;
    ris_nxt       = ris_r;
    count_nxt     = count_r;
    out_count_nxt = out_count_r;

    // fold the registered product into its target
    if (pvalid_r) begin
      case (ptgt_r)
        SEL_RR:  rr_nxt = acc_sum;
        SEL_II:  ii_nxt = acc_sum;
        SEL_RI:  ri_nxt = acc_sum;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (mode_r == MODE_JULIA) begin
            z_re_nxt = ZW'(in_point_re);
            z_im_nxt = ZW'(in_point_im);
            c_re_nxt = jre_r;
            c_im_nxt = jim_r;
          end else begin
            z_re_nxt = '0;
            z_im_nxt = '0;
            c_re_nxt = in_point_re;
            c_im_nxt = in_point_im;
          end
          count_nxt = '0;
          state_nxt = S_MAG;
        end
      end

      S_MAG: begin
        mr_nxt    = mag_re;
        mi_nxt    = mag_im;
        rineg_nxt = (z_re_r[ZW-1] ^ z_im_r[ZW-1]) ^ (mode_r == MODE_TRICORN);
        b_sh_nxt  = BPW'(mag_re);
        sel_nxt   = SEL_RR;
        dig_nxt   = '0;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        if (sel_r != SEL_DONE) begin
          // issue one digit pass
          pvalid_nxt = 1'b1;
          ptgt_nxt   = sel_r;
          pfirst_nxt = (dig_r == '0);
          if (dig_r == DGW'(ND - 1)) begin
            dig_nxt  = '0;
            sel_nxt  = sel_t'(sel_r + 2'd1);
            b_sh_nxt = BPW'(mi_r);
          end else begin
            dig_nxt  = dig_r + DGW'(1);
            b_sh_nxt = b_sh_r << MUL_DIG_W;
          end
        end else begin
          // last product folds in this cycle
          state_nxt = S_TEST;
        end
      end

      S_TEST: begin
        if ((count_r >= max_iter_r) || (sum_sq > LIMIT)) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = S_IDLE;
        end else begin
          diff_nxt  = $signed({1'b0, rr_r}) - $signed({1'b0, ii_r});
          ris_nxt   = rineg_r ? -ri_pos : ri_pos;
          state_nxt = S_UPD;
        end
      end

      S_UPD: begin
        z_re_nxt  = nre_sh[ZW-1:0] + {{(ZW - DATA_W){c_re_r[DATA_W-1]}}, c_re_r};
        z_im_nxt  = nim_sh[ZW-1:0] + {{(ZW - DATA_W){c_im_r[DATA_W-1]}}, c_im_r};
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_MAG;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, strobe, result and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_count_r <= '0;
      pvalid_r    <= 1'b0;
      mode_r      <= MODE_MANDEL;
      jre_r       <= JRE_RST;
      jim_r       <= JIM_RST;
      max_iter_r  <= MAXIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_count_r <= out_count_nxt;
      pvalid_r    <= pvalid_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_MODE:  mode_r     <= pwdata[MODE_W-1:0];
          REG_JRE:   jre_r      <= pwdata;
          REG_JIM:   jim_r      <= pwdata;
          REG_MAXIT: max_iter_r <= pwdata[CNT_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    z_re_r      <= z_re_nxt;
    z_im_r      <= z_im_nxt;
    c_re_r      <= c_re_nxt;
    c_im_r      <= c_im_nxt;
    mr_r        <= mr_nxt;
    mi_r        <= mi_nxt;
    rineg_r     <= rineg_nxt;
    b_sh_r      <= b_sh_nxt;
    sel_r       <= sel_nxt;
    ptgt_r      <= ptgt_nxt;
    dig_r       <= dig_nxt;
    pfirst_r    <= pfirst_nxt;
    prod_r      <= prod_nxt;
    rr_r        <= rr_nxt;
    ii_r        <= ii_nxt;
    ri_r        <= ri_nxt;
    diff_r      <= diff_nxt;
    ris_r       <= ris_nxt;
    count_r     <= count_nxt;
  end

  // checks
  `ETFI_ASSERT(a_start_sets_busy, start && !busy |=> busy)
  `ETFI_ASSERT(a_strobe_one_cycle, out_valid |=> !out_valid)
  `ETFI_ASSERT(a_strobe_after_test, out_valid |-> $past(state_r == S_TEST))
  `ETFI_ASSERT(a_upd_below_limit, state_r == S_UPD |-> count_r < $past(max_iter_r))
  `ETFI_ASSERT_NEVER(a_no_product_outside_mul, pvalid_r && state_r != S_MUL)

endmodule
